FILE: hw/rtl/cfhp_pkg.sv
// Shared types and constants for the cache frame header parser.
// Used by every module under hw/rtl; depends on nothing.
package cfhp_pkg;

  localparam int HEADER_BYTES      = 24;
  localparam int HDR_STORE_DEPTH   = HEADER_BYTES - 1;
  localparam logic [4:0] HDR_LAST_IDX = 5'(HEADER_BYTES - 1);
  localparam logic [31:0] MAGIC_WORD = 32'h0000_0000;
  localparam logic [7:0]  PROTOCOL_VERSION = 8'h01;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [2:0] CFG_PARSE_RESPONSES = 3'd0;
  localparam logic [2:0] CFG_OPCODE_VALID    = 3'd1;
  localparam logic [2:0] CFG_OPCODE_NEEDS_KEY = 3'd2;
  localparam logic [2:0] CFG_OPCODE_ALLOWS_VAL = 3'd3;
  localparam logic [2:0] CFG_STATUS_VALID    = 3'd4;
  localparam logic [2:0] CFG_MAX_KEY         = 3'd5;
  localparam logic [2:0] CFG_MAX_VALUE       = 3'd6;
  localparam logic [2:0] CFG_MAX_FRAME       = 3'd7;

  localparam logic [33:0] MAX_FRAME_RESET = 34'(HEADER_BYTES);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_KEY    = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_VALUE  = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_MAGIC       = 4'd1,
    ERR_VERSION     = 4'd2,
    ERR_OPCODE      = 4'd3,
    ERR_FLAGS       = 4'd4,
    ERR_STATUS      = 4'd5,
    ERR_KEY_LARGE   = 4'd6,
    ERR_VALUE_LARGE = 4'd7,
    ERR_MISSING_KEY = 4'd8,
    ERR_NOT_ALLOWED = 4'd9
  } err_t;

  typedef struct packed {
    logic        parse_responses;
    logic [63:0] opcode_valid_mask;
    logic [63:0] opcode_needs_key_mask;
    logic [63:0] opcode_allows_value_mask;
    logic [63:0] status_valid_mask;
    logic [31:0] key_limit;
    logic [31:0] value_limit;
    logic [33:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  opcode;
    logic [7:0]  frame_status;
    logic [63:0] frame_id;
    logic [31:0] key_length;
    logic [31:0] value_length;
    err_t        error_code;
    logic        last;
  } result_t;

  // Look up bit n of a 64-bit mask; codes of 64 and above read as clear.
  function automatic logic mask_bit(input logic [63:0] mask, input logic [7:0] n);
    mask_bit = (n[7:6] == 2'b00) && mask[n[5:0]];
  endfunction

endpackage

FILE: hw/rtl/cfhp_front.sv
// Front end: captures header bytes, runs the header checks, tracks key
// and value counts and emits one result per item that has one. Uses cfhp_pkg.
module cfhp_front import cfhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output logic       push,
  output result_t    push_data
);

  phase_t      phase, phase_next;
  logic [4:0]  byte_index, byte_index_next;
  logic [31:0] key_left, key_left_next;
  logic [31:0] value_left, value_left_next;

  logic [7:0]  hdr [HDR_STORE_DEPTH];

  logic [31:0] magic, klen, vlen;
  logic [7:0]  ver, op, st, flags;
  logic [63:0] req_id;
  logic [33:0] frame_total;
  logic        needs_key;
  err_t        err;
  logic [31:0] key_dec, value_dec;

  // Header store: bytes 0..22 land here, byte 23 is used live.
  always_ff @(posedge clk) begin
    if (accept && !action && phase == PH_HEADER && byte_index != HDR_LAST_IDX) begin
      hdr[byte_index] <= data_byte;
    end
  end

  always_comb begin
    magic  = {hdr[0], hdr[1], hdr[2], hdr[3]};
    ver    = hdr[4];
    op     = hdr[5];
    flags  = hdr[6];
    st     = hdr[7];
    req_id = {hdr[8], hdr[9], hdr[10], hdr[11], hdr[12], hdr[13], hdr[14], hdr[15]};
    klen   = {hdr[16], hdr[17], hdr[18], hdr[19]};
    vlen   = {hdr[20], hdr[21], hdr[22], data_byte};
    frame_total = 34'(HEADER_BYTES) + {2'b00, klen} + {2'b00, vlen};
    needs_key  = mask_bit(cfg.opcode_needs_key_mask, op);

    if (magic != MAGIC_WORD) begin
      err = ERR_MAGIC;
    end else if (ver != PROTOCOL_VERSION) begin
      err = ERR_VERSION;
    end else if (!mask_bit(cfg.opcode_valid_mask, op)) begin
      err = ERR_OPCODE;
    end else if (flags != 8'h00) begin
      err = ERR_FLAGS;
    end else if (cfg.parse_responses) begin
      if (!mask_bit(cfg.status_valid_mask, st)) begin
        err = ERR_STATUS;
      end else if (klen != 32'd0) begin
        err = ERR_NOT_ALLOWED;
      end else if (vlen > cfg.value_limit) begin
        err = ERR_VALUE_LARGE;
      end else begin
        err = ERR_NONE;
      end
    end else if (st != 8'h00) begin
      err = ERR_STATUS;
    end else if (klen > cfg.key_limit) begin
      err = ERR_KEY_LARGE;
    end else if (vlen > cfg.value_limit) begin
      err = ERR_VALUE_LARGE;
    end else if (needs_key && klen == 32'd0) begin
      err = ERR_MISSING_KEY;
    end else if (!needs_key && klen != 32'd0) begin
      err = ERR_NOT_ALLOWED;
    end else if (!mask_bit(cfg.opcode_allows_value_mask, op) && vlen != 32'd0) begin
      err = ERR_NOT_ALLOWED;
    end else if (frame_total > cfg.max_frame_bytes) begin
      err = ERR_VALUE_LARGE;
    end else begin
      err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_index <= '0;
      key_left   <= '0;
      value_left <= '0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      key_left   <= key_left_next;
      value_left <= value_left_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    key_left_next   = key_left;
    value_left_next = value_left;
    push            = 1'b0;
    push_data       = '0;
    key_dec   = key_left - {31'd0, (key_left != 32'd0)};
    value_dec = value_left - {31'd0, (value_left != 32'd0)};

    if (accept) begin
      if (action) begin
        // resync: expect a fresh header
        phase_next      = PH_HEADER;
        byte_index_next = '0;
        key_left_next   = '0;
        value_left_next = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (byte_index != HDR_LAST_IDX) begin
              byte_index_next = byte_index + 5'd1;
            end else begin
              byte_index_next = '0;
              push = 1'b1;
              if (err != ERR_NONE) begin
                phase_next           = PH_DROP;
                push_data.kind       = KIND_BAD;
                push_data.error_code = err;
                push_data.last       = 1'b1;
              end else begin
                key_left_next          = klen;
                value_left_next        = vlen;
                push_data.kind         = KIND_HEADER;
                push_data.opcode       = op;
                push_data.frame_status = st;
                push_data.frame_id     = req_id;
                push_data.key_length   = klen;
                push_data.value_length = vlen;
                if (klen != 32'd0) begin
                  phase_next = PH_KEY;
                end else if (vlen != 32'd0) begin
                  phase_next = PH_VALUE;
                end else begin
                  push_data.last = 1'b1;
                end
              end
            end
          end
          PH_KEY: begin
            push                   = 1'b1;
            push_data.kind         = KIND_KEY;
            push_data.payload_byte = data_byte;
            key_left_next          = key_dec;
            if (key_dec == 32'd0) begin
              if (value_left != 32'd0) begin
                phase_next = PH_VALUE;
              end else begin
                phase_next     = PH_HEADER;
                push_data.last = 1'b1;
              end
            end
          end
          PH_VALUE: begin
            push                   = 1'b1;
            push_data.kind         = KIND_VALUE;
            push_data.payload_byte = data_byte;
            value_left_next        = value_dec;
            if (value_dec == 32'd0) begin
              phase_next     = PH_HEADER;
              push_data.last = 1'b1;
            end
          end
          default: begin
            // drop until resync
          end
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/cfhp_queue.sv
// Short result queue between the parser front end and the output stage.
// Uses cfhp_pkg for the result type and depth.
module cfhp_queue import cfhp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output result_t pop_data,
  output logic    empty,
  output logic    full
);

  result_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;

  assign empty    = (count == '0);
  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cfhp_back.sv
// Output stage: pulls results from the queue into a registered master beat
// and holds it until taken. Uses cfhp_pkg for the result type.
module cfhp_back import cfhp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  result_t q_data,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule

FILE: hw/rtl/cache_frame_header_parser.sv
// Deframer for binary cache request/response frames: a 24-byte header
// then key and value bytes. Depends on cfhp_pkg, cfhp_front, cfhp_queue, cfhp_back.
//
// Takes one stream byte per beat on the slave side, one beat every cycle,
// as long as the four-entry result queue has room; the output side drains
// one result per cycle, so with tready held high the rate is one byte per
// cycle. A result reaches the master side by way of a queue entry, which the
// front end writes at the accepting edge, and then of the output register,
// which loads from the queue.
// The header checks run on the beat carrying the last header byte. A
// malformed header yields one result with an error code and tlast, after
// which bytes are dropped until a beat with action set (resync). Write the
// configuration registers only while the parser is idle; cfg_ready is
// always high.
module cache_frame_header_parser import cfhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // byte stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] action (1 = resync)
  // results out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] opcode,
                                       // [23:16] frame_status, [87:24] frame_id,
                                       // [119:88] key_length, [151:120] value_length,
                                       // [155:152] error_code, [159:156] zero
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast
);

  cfg_t    cfg;
  logic    in_accept;
  logic    push, pop, q_empty, q_full;
  result_t push_data, q_data, out_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parse_responses          <= 1'b0;
      cfg.opcode_valid_mask        <= '0;
      cfg.opcode_needs_key_mask    <= '0;
      cfg.opcode_allows_value_mask <= '0;
      cfg.status_valid_mask        <= '0;
      cfg.key_limit                <= '0;
      cfg.value_limit              <= '0;
      cfg.max_frame_bytes          <= MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PARSE_RESPONSES:   cfg.parse_responses          <= cfg_data[0];
        CFG_OPCODE_VALID:      cfg.opcode_valid_mask        <= cfg_data;
        CFG_OPCODE_NEEDS_KEY:  cfg.opcode_needs_key_mask    <= cfg_data;
        CFG_OPCODE_ALLOWS_VAL: cfg.opcode_allows_value_mask <= cfg_data;
        CFG_STATUS_VALID:      cfg.status_valid_mask        <= cfg_data;
        CFG_MAX_KEY:           cfg.key_limit                <= cfg_data[31:0];
        CFG_MAX_VALUE:         cfg.value_limit              <= cfg_data[31:0];
        CFG_MAX_FRAME:         cfg.max_frame_bytes          <= cfg_data[33:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off input only when the queue cannot take another result
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cfhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .action    (s_axis_tuser),
    .data_byte (s_axis_tdata),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data)
  );

  cfhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  cfhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  // Pack the result beat, first field in the lowest bits
  assign m_axis_tdata = {4'b0000, out_data.error_code, out_data.value_length,
                         out_data.key_length, out_data.frame_id,
                         out_data.frame_status, out_data.opcode,
                         out_data.payload_byte};
  assign m_axis_tuser = out_data.kind;
  assign m_axis_tlast = out_data.last;

  // A malformed result always closes the frame and carries a nonzero code
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_BAD) |->
      (m_axis_tlast && m_axis_tdata[155:152] != ERR_NONE))
    else $error("malformed result without tlast or error code");

  // Header, key and value results carry no error code
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_BAD) |-> (m_axis_tdata[155:152] == ERR_NONE))
    else $error("error code on a good result");

  // The queue is never both full and empty
  assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue full and empty at once");

  // A result pushed into an empty queue with the output free reaches the output
  assert property (@(posedge clk) disable iff (rst)
    (push && q_empty && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
    else $error("result lost between front end and output stage");

endmodule

FILE: bench/cache_frame_header_parser_tb.sv
// Self-checking bench for cache_frame_header_parser: directed frame cases, then
// random frames under random configuration, with stalls on both stream sides.
// Depends on cfhp_pkg and the parser RTL only.
module cache_frame_header_parser_tb;
  import cfhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_SETTLE = 4;    // cycles for a dropped or header beat to clear
  localparam int END_SETTLE = 20;
  localparam int MAX_PRINTED = 40;

  // Frame header as it travels: magic in the first four bytes, big-endian.
  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  opcode;
    logic [7:0]  flags;
    logic [7:0]  status;
    logic [63:0] id;
    logic [31:0] key_len;
    logic [31:0] val_len;
  } frame_hdr_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  cache_frame_header_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] action (1 = resync)
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // payload, opcode, status, id, lengths, error, pad
    .m_axis_tuser  (m_axis_tuser),   // [1:0] kind
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow of the parser: configuration, header store, position and counters.
  cfg_t        shadow_cfg;
  logic [7:0]  hdr_store [0:HEADER_BYTES-1];
  int unsigned hdr_pos;
  phase_t      parse_phase;
  logic [31:0] key_left;
  logic [31:0] value_left;

  result_t     awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned useful_beats = 0;

  // Idle knobs, in percent per cycle; hold_request asks the receiver for a long hold-off.
  int unsigned in_idle_pct = 18;
  int unsigned out_stall_pct = 18;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  // Result beat as sampled on the falling edge before the accepting rising edge.
  logic         result_seen = 1'b0;
  logic [159:0] seen_data;
  logic [1:0]   seen_kind;
  logic         seen_last;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    shadow_cfg = '0;
    shadow_cfg.max_frame_bytes = 34'(HEADER_BYTES);
    foreach (hdr_store[i]) hdr_store[i] = '0;
    hdr_pos = 0;
    parse_phase = PH_HEADER;
    key_left = '0;
    value_left = '0;
  endfunction

  // Read count header bytes from pos as one big-endian number.
  function automatic logic [63:0] hdr_be(input int pos, input int count);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < count; i++) v = {v[55:0], hdr_store[pos + i]};
    return v;
  endfunction

  // Codes of 64 and up never have a mask bit.
  function automatic logic code_enabled(input logic [63:0] mask, input logic [7:0] code);
    return (code < 8'd64) && mask[code[5:0]];
  endfunction

  // Run the header checks in their fixed order; the first failure wins.
  function automatic err_t header_error();
    logic [7:0]  op;
    logic [7:0]  st;
    logic [31:0] klen;
    logic [31:0] vlen;
    logic        needs_key;
    logic [35:0] total;
    op = hdr_store[5];
    st = hdr_store[7];
    klen = hdr_be(16, 4);
    vlen = hdr_be(20, 4);
    if (hdr_be(0, 4) != 64'(MAGIC_WORD)) return ERR_MAGIC;
    if (hdr_store[4] != PROTOCOL_VERSION) return ERR_VERSION;
    if (!code_enabled(shadow_cfg.opcode_valid_mask, op)) return ERR_OPCODE;
    if (hdr_store[6] != 8'd0) return ERR_FLAGS;
    if (shadow_cfg.parse_responses) begin
      // Response frames: no frame-size limit, and no key at all.
      if (!code_enabled(shadow_cfg.status_valid_mask, st)) return ERR_STATUS;
      if (klen != 0) return ERR_NOT_ALLOWED;
      if (vlen > shadow_cfg.value_limit) return ERR_VALUE_LARGE;
      return ERR_NONE;
    end
    if (st != 8'd0) return ERR_STATUS;
    if (klen > shadow_cfg.key_limit) return ERR_KEY_LARGE;
    if (vlen > shadow_cfg.value_limit) return ERR_VALUE_LARGE;
    needs_key = code_enabled(shadow_cfg.opcode_needs_key_mask, op);
    if (needs_key && klen == 0) return ERR_MISSING_KEY;
    if (!needs_key && klen != 0) return ERR_NOT_ALLOWED;
    if (!code_enabled(shadow_cfg.opcode_allows_value_mask, op) && vlen != 0)
      return ERR_NOT_ALLOWED;
    // Oversized frame is flagged as a value that is too large.
    total = 36'(HEADER_BYTES) + 36'(klen) + 36'(vlen);
    if (total > 36'(shadow_cfg.max_frame_bytes)) return ERR_VALUE_LARGE;
    return ERR_NONE;
  endfunction

  // Advance the shadow by one accepted input beat; return 1 when it yields a result.
  function automatic logic deframe_byte(input logic act, input logic [7:0] b,
                                        output result_t res);
    err_t err;
    res = '0;
    if (act) begin
      hdr_pos = 0;
      parse_phase = PH_HEADER;
      key_left = '0;
      value_left = '0;
      return 1'b0;
    end
    case (parse_phase)
      PH_HEADER: begin
        hdr_store[hdr_pos] = b;
        if (hdr_pos < HEADER_BYTES - 1) begin
          hdr_pos++;
          return 1'b0;
        end
        hdr_pos = 0;
        err = header_error();
        if (err != ERR_NONE) begin
          parse_phase = PH_DROP;
          res.kind = KIND_BAD;
          res.error_code = err;
          res.last = 1'b1;
          return 1'b1;
        end
        key_left = hdr_be(16, 4);
        value_left = hdr_be(20, 4);
        res.kind = KIND_HEADER;
        res.opcode = hdr_store[5];
        res.frame_status = hdr_store[7];
        res.frame_id = hdr_be(8, 8);
        res.key_length = key_left;
        res.value_length = value_left;
        if (key_left != 0) begin
          parse_phase = PH_KEY;
        end else if (value_left != 0) begin
          parse_phase = PH_VALUE;
        end else begin
          res.last = 1'b1;
        end
        return 1'b1;
      end
      PH_KEY: begin
        res.kind = KIND_KEY;
        res.payload_byte = b;
        if (key_left != 0) key_left--;
        if (key_left == 0) begin
          if (value_left != 0) begin
            parse_phase = PH_VALUE;
          end else begin
            parse_phase = PH_HEADER;
            res.last = 1'b1;
          end
        end
        return 1'b1;
      end
      PH_VALUE: begin
        res.kind = KIND_VALUE;
        res.payload_byte = b;
        if (value_left != 0) value_left--;
        if (value_left == 0) begin
          parse_phase = PH_HEADER;
          res.last = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;   // drop everything until a resync
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Inputs change only at rising edges, so the falling edge sees the settled beat.
  always @(negedge clk) begin
    result_seen = m_axis_tvalid && m_axis_tready && !rst;
    seen_data = m_axis_tdata;
    seen_kind = m_axis_tuser;
    seen_last = m_axis_tlast;
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (result_seen) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with no prediction waiting");
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", seen_kind, want.kind);
        check_field("payload_byte", seen_data[7:0], want.payload_byte);
        check_field("opcode", seen_data[15:8], want.opcode);
        check_field("frame_status", seen_data[23:16], want.frame_status);
        check_field("frame_id", seen_data[87:24], want.frame_id);
        check_field("key_length", seen_data[119:88], want.key_length);
        check_field("value_length", seen_data[151:120], want.value_length);
        check_field("error_code", seen_data[155:152], want.error_code);
        check_field("pad", seen_data[159:156], '0);
        check_field("last", seen_last, want.last);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat, with a random gap first; predict on acceptance.
  task automatic send_beat(input logic act, input logic [7:0] b);
    logic    fired;
    result_t res;
    if ($urandom_range(99) < in_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= act;
    do begin
      @(negedge clk);
      fired = s_axis_tready;
      @(posedge clk);
    end while (!fired);
    if (!act && parse_phase != PH_DROP) useful_beats++;
    if (deframe_byte(act, b, res)) awaited_results.insert(awaited_results.size(), res);
  endtask

  task automatic resync_stream();
    send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  // Drop valid and wait for every predicted result to come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Write one register once all predicted results are out, then mirror it in the shadow.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    logic fired;
    drain();
    repeat (DRAIN_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      fired = cfg_ready;
      @(posedge clk);
    end while (!fired);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PARSE_RESPONSES:   shadow_cfg.parse_responses = val[0];
      CFG_OPCODE_VALID:      shadow_cfg.opcode_valid_mask = val;
      CFG_OPCODE_NEEDS_KEY:  shadow_cfg.opcode_needs_key_mask = val;
      CFG_OPCODE_ALLOWS_VAL: shadow_cfg.opcode_allows_value_mask = val;
      CFG_STATUS_VALID:      shadow_cfg.status_valid_mask = val;
      CFG_MAX_KEY:           shadow_cfg.key_limit = val[31:0];
      CFG_MAX_VALUE:         shadow_cfg.value_limit = val[31:0];
      CFG_MAX_FRAME:         shadow_cfg.max_frame_bytes = val[33:0];
      default: ;
    endcase
  endtask

  // Well-formed request header with a random id.
  function automatic frame_hdr_t make_header(input logic [7:0] op, input logic [31:0] klen,
                                             input logic [31:0] vlen);
    frame_hdr_t h;
    h.magic = MAGIC_WORD;
    h.version = PROTOCOL_VERSION;
    h.opcode = op;
    h.flags = '0;
    h.status = '0;
    h.id = {$urandom, $urandom};
    h.key_len = klen;
    h.val_len = vlen;
    return h;
  endfunction

  // Send the 24 header bytes, then payload random bytes, then optionally a resync.
  task automatic send_frame(input frame_hdr_t h, input int unsigned payload,
                            input bit resync_after);
    for (int i = 0; i < HEADER_BYTES; i++) send_beat(1'b0, h[191 - 8 * i -: 8]);
    repeat (payload) send_beat(1'b0, 8'($urandom_range(255)));
    if (resync_after) resync_stream();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All masks clear after reset: any opcode is rejected, magic still checked first.
  task automatic test_reset_defaults();
    frame_hdr_t h;
    h = make_header(8'd0, '0, '0);
    send_frame(h, 3, 1'b1);
    h.magic = 32'hDEAD_BEEF;
    send_frame(h, 0, 1'b1);
  endtask

  // Request mode: accepted shapes, every rejection, resync from each phase.
  task automatic test_request_checks();
    frame_hdr_t h;
    write_reg(CFG_PARSE_RESPONSES, 64'd0);
    write_reg(CFG_OPCODE_VALID, ~(64'd1 << 40));
    write_reg(CFG_OPCODE_NEEDS_KEY, 64'h0000_0000_0000_00F0);
    write_reg(CFG_OPCODE_ALLOWS_VAL, 64'h0000_0000_0000_00CC);
    write_reg(CFG_STATUS_VALID, 64'h0000_0000_0000_0003);
    write_reg(CFG_MAX_KEY, 64'd8);
    write_reg(CFG_MAX_VALUE, 64'd8);
    write_reg(CFG_MAX_FRAME, 64'd36);

    // Accepted: empty frame, key only, key and value, value only.
    send_frame(make_header(8'd1, 32'd0, 32'd0), 0, 1'b0);
    send_frame(make_header(8'd4, 32'd3, 32'd0), 3, 1'b0);
    send_frame(make_header(8'd6, 32'd2, 32'd3), 5, 1'b0);
    send_frame(make_header(8'd2, 32'd0, 32'd4), 4, 1'b0);

    // Resync while idle, mid header, mid key, mid value.
    resync_stream();
    repeat (10) send_beat(1'b0, 8'($urandom_range(255)));
    resync_stream();
    send_frame(make_header(8'd6, 32'd4, 32'd4), 2, 1'b1);
    send_frame(make_header(8'd6, 32'd4, 32'd4), 6, 1'b1);

    // Rejections; trailing bytes are dropped until the resync.
    h = make_header(8'd1, 32'd0, 32'd0);
    h.magic = 32'hFFFF_FFFF;
    send_frame(h, 5, 1'b1);
    h = make_header(8'd1, 32'd0, 32'd0);
    h.version = 8'hFE;
    send_frame(h, 2, 1'b1);
    send_frame(make_header(8'd40, 32'd0, 32'd0), 2, 1'b1);
    send_frame(make_header(8'd255, 32'd0, 32'd0), 2, 1'b1);
    h = make_header(8'd1, 32'd0, 32'd0);
    h.flags = 8'hFF;
    send_frame(h, 2, 1'b1);
    h = make_header(8'd1, 32'd0, 32'd0);
    h.status = 8'h80;
    send_frame(h, 2, 1'b1);
    send_frame(make_header(8'd4, 32'd9, 32'd0), 2, 1'b1);   // key over limit
    send_frame(make_header(8'd6, 32'd1, 32'd9), 2, 1'b1);   // value over limit
    send_frame(make_header(8'd4, 32'd0, 32'd0), 2, 1'b1);   // key missing
    send_frame(make_header(8'd1, 32'd1, 32'd0), 2, 1'b1);   // key not wanted
    send_frame(make_header(8'd1, 32'd0, 32'd1), 2, 1'b1);   // value not allowed
    send_frame(make_header(8'd6, 32'd6, 32'd7), 2, 1'b1);   // frame too big
  endtask

  // Response mode: status by mask, no key, value limit, no frame-size check.
  task automatic test_response_checks();
    frame_hdr_t h;
    write_reg(CFG_PARSE_RESPONSES, 64'd1);
    write_reg(CFG_STATUS_VALID, 64'h8000_0000_0000_0005);
    write_reg(CFG_MAX_FRAME, 64'd24);

    h = make_header(8'd1, 32'd0, 32'd8);
    h.status = 8'd2;
    send_frame(h, 8, 1'b0);
    h = make_header(8'd3, 32'd0, 32'd0);
    h.status = 8'd63;
    send_frame(h, 0, 1'b0);
    h = make_header(8'd1, 32'd0, 32'd0);
    h.status = 8'd1;
    send_frame(h, 2, 1'b1);
    h.status = 8'hC0;
    send_frame(h, 2, 1'b1);
    send_frame(make_header(8'd1, 32'd2, 32'd0), 2, 1'b1);
    send_frame(make_header(8'd1, 32'd0, 32'd9), 2, 1'b1);
    h = make_header(8'd1, 32'd0, 32'd0);
    h.flags = 8'h01;
    send_frame(h, 2, 1'b1);
  endtask

  // Flip the mode in the middle of a payload; the payload keeps the accepted lengths.
  task automatic test_mode_change_midframe();
    write_reg(CFG_PARSE_RESPONSES, 64'd0);
    write_reg(CFG_MAX_FRAME, 64'd40);
    send_frame(make_header(8'd7, 32'd4, 32'd2), 2, 1'b0);
    write_reg(CFG_PARSE_RESPONSES, 64'd1);
    repeat (4) send_beat(1'b0, 8'($urandom_range(255)));
  endtask

  // Widest registers and header fields, then limits of zero.
  task automatic test_field_extremes();
    frame_hdr_t h;
    write_reg(CFG_PARSE_RESPONSES, 64'd0);
    write_reg(CFG_OPCODE_VALID, '1);
    write_reg(CFG_OPCODE_NEEDS_KEY, '1);
    write_reg(CFG_OPCODE_ALLOWS_VAL, '1);
    write_reg(CFG_STATUS_VALID, '1);
    write_reg(CFG_MAX_KEY, 64'hFFFF_FFFF);
    write_reg(CFG_MAX_VALUE, 64'hFFFF_FFFF);
    write_reg(CFG_MAX_FRAME, 64'h2_0000_0016);

    // Largest lengths exactly fill the largest frame.
    h = make_header(8'd63, '1, '1);
    h.id = '1;
    send_frame(h, 6, 1'b1);
    write_reg(CFG_MAX_FRAME, 64'h2_0000_0015);
    send_frame(h, 2, 1'b1);

    write_reg(CFG_MAX_KEY, 64'd0);
    h = make_header(8'd0, 32'd1, 32'd0);
    h.id = '0;
    send_frame(h, 1, 1'b1);
    write_reg(CFG_MAX_VALUE, 64'd0);
    send_frame(make_header(8'd0, 32'd0, 32'd1), 1, 1'b1);
  endtask

  // Hold the receiver off while a long frame streams in, so the input stalls.
  task automatic test_backpressure();
    write_reg(CFG_MAX_KEY, 64'd64);
    write_reg(CFG_MAX_VALUE, 64'd64);
    hold_request = 300;
    send_frame(make_header(8'd5, 32'd40, 32'd40), 80, 1'b0);
  endtask

  // Random register set: small limits so frames stay short.
  task automatic randomize_config();
    write_reg(CFG_PARSE_RESPONSES, 64'($urandom_range(1)));
    write_reg(CFG_OPCODE_VALID, {$urandom, $urandom} | 64'hFF);
    write_reg(CFG_OPCODE_NEEDS_KEY, {$urandom, $urandom});
    write_reg(CFG_OPCODE_ALLOWS_VAL, {$urandom, $urandom});
    write_reg(CFG_STATUS_VALID, {$urandom, $urandom} | 64'h1);
    write_reg(CFG_MAX_KEY, 64'($urandom_range(8)));
    write_reg(CFG_MAX_VALUE, 64'($urandom_range(8)));
    write_reg(CFG_MAX_FRAME, 64'(HEADER_BYTES + $urandom_range(16)));
  endtask

  // Mostly well-formed frames for the current setting; some corrupted, cut or noise.
  task automatic send_random_frame();
    frame_hdr_t  h;
    logic [7:0]  op;
    logic [7:0]  st;
    int unsigned klen_cap;
    int unsigned vlen_cap;
    int unsigned klen;
    int unsigned vlen;
    longint      room;
    int unsigned payload;
    int unsigned pick;
    int unsigned pos;
    op = 8'($urandom_range(63));
    repeat (8) if (!shadow_cfg.opcode_valid_mask[op[5:0]]) op = 8'($urandom_range(63));
    if ($urandom_range(49) == 0) op = 8'($urandom_range(255, 64));
    klen_cap = (shadow_cfg.key_limit > 6) ? 6 : shadow_cfg.key_limit;
    vlen_cap = (shadow_cfg.value_limit > 6) ? 6 : shadow_cfg.value_limit;
    klen = 0;
    vlen = 0;
    if (!shadow_cfg.parse_responses && shadow_cfg.opcode_needs_key_mask[op[5:0]])
      klen = $urandom_range(klen_cap, 1);
    if (shadow_cfg.parse_responses || shadow_cfg.opcode_allows_value_mask[op[5:0]])
      vlen = $urandom_range(vlen_cap);
    if (!shadow_cfg.parse_responses) begin
      // Trim the value so the whole frame fits.
      room = longint'(shadow_cfg.max_frame_bytes) - HEADER_BYTES;
      if (longint'(klen + vlen) > room) vlen = (room > klen) ? int'(room) - klen : 0;
    end
    h = make_header(op, klen, vlen);
    if (shadow_cfg.parse_responses) begin
      st = 8'($urandom_range(63));
      repeat (8) if (!shadow_cfg.status_valid_mask[st[5:0]]) st = 8'($urandom_range(63));
      h.status = st;
    end
    payload = klen + vlen;
    pick = $urandom_range(99);
    if (pick < 12) begin
      pos = $urandom_range(HEADER_BYTES - 1);
      h[191 - 8 * pos -: 8] = h[191 - 8 * pos -: 8] ^ 8'($urandom_range(255, 1));
    end else if (pick < 22) begin
      payload = $urandom_range(payload);
    end else if (pick < 26) begin
      h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    send_frame(h, payload, 1'b0);
    // Recover from a rejected or unfinished frame; sometimes resync anyway.
    if (parse_phase != PH_HEADER || hdr_pos != 0 || $urandom_range(9) == 0)
      resync_stream();
  endtask

  task automatic test_random_traffic();
    int unsigned start_beats;
    for (int p = 0; p < 5; p++) begin
      randomize_config();
      // One whole setting runs with no gaps on either side.
      in_idle_pct = (p == 2) ? 0 : 18;
      out_stall_pct = (p == 2) ? 0 : 18;
      start_beats = useful_beats;
      while (useful_beats - start_beats < 60) send_random_frame();
    end
    in_idle_pct = 18;
    out_stall_pct = 18;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_request_checks();
    test_response_checks();
    test_mode_change_midframe();
    test_field_extremes();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
